// ===== hdl/dtsi_pkg.sv =====
// Shared types and constants for the depth-to-space index unit.
package dtsi_pkg;

  localparam int unsigned CFG_W     = 16;  // widest config register
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BLOCK_W   = 7;   // block edge register width

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLK_EDGE   = 3'd0,
    REG_OUT_DEPTH  = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3,
    REG_IN_DEPTH   = 3'd4,
    REG_IN_WIDTH   = 3'd5,
    REG_IN_HEIGHT  = 3'd6
  } cfg_reg_e;

endpackage

// ===== hdl/dtsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module dtsi_div #(
  parameter int unsigned NW = 32,  // dividend / quotient width
  parameter int unsigned DW = 16,  // divisor / remainder width
  parameter int unsigned PW = 32   // payload width
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,   // nonzero, static while busy
  input  logic [PW-1:0] payload_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o,
  output logic [PW-1:0] payload_o
);

  logic          v_q   [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];  // dividend bits shift out, quotient bits shift in
  logic [PW-1:0] pl_q  [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [NW-1:0] n_in;
    logic [PW-1:0] p_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = '0;
      assign n_in = dividend_i;
      assign p_in = payload_i;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign r_in = rem_q[s-1];
      assign n_in = num_q[s-1];
      assign p_in = pl_q[s-1];
    end

    assign trial = {r_in, n_in[NW-1]};
    assign ge    = (trial >= {1'b0, divisor_i});
    assign diff  = trial - {1'b0, divisor_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_q[s] <= {n_in[NW-2:0], ge};
        pl_q[s]  <= p_in;
      end
    end
  end

  assign valid_o   = v_q[NW-1];
  assign quot_o    = num_q[NW-1];
  assign rem_o     = rem_q[NW-1];
  assign payload_o = pl_q[NW-1];

endmodule

// ===== hdl/depth_to_space_index_unit.sv =====
// Depth-to-space (NHWC) source index generator: top level.
// Structure: five bit-per-stage divider pipelines plus four multiply/add stages.
// Throughput: one beat per cycle; the whole pipe holds when the output beat is stalled.
// Reset: valid bits clear; all config registers return to 1.
module depth_to_space_index_unit #(
  parameter int unsigned INDEX_BITS = 32,
  parameter int unsigned DIM_BITS   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [dtsi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dtsi_pkg::CFG_W-1:0]       cfg_data_i,
  // input beat
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic [INDEX_BITS-1:0]            out_index_i,
  // output beat
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic [INDEX_BITS-1:0]            dest_index_o,
  output logic [INDEX_BITS-1:0]            source_index_o
);

  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned DB = DIM_BITS;
  localparam int unsigned BW = dtsi_pkg::BLOCK_W;
  localparam int unsigned CW = dtsi_pkg::CFG_W;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [BW-1:0] blk_edge_q;
  logic [CW-1:0] out_depth_q, out_width_q, out_height_q;
  logic [CW-1:0] in_depth_q, in_width_q, in_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_edge_q   <= BW'(1);
      out_depth_q  <= CW'(1);
      out_width_q  <= CW'(1);
      out_height_q <= CW'(1);
      in_depth_q   <= CW'(1);
      in_width_q   <= CW'(1);
      in_height_q  <= CW'(1);
    end else if (cfg_we_i) begin
      unique case (dtsi_pkg::cfg_reg_e'(cfg_idx_i))
        dtsi_pkg::REG_BLK_EDGE:   blk_edge_q   <= cfg_data_i[BW-1:0];
        dtsi_pkg::REG_OUT_DEPTH:  out_depth_q  <= cfg_data_i;
        dtsi_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data_i;
        dtsi_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data_i;
        dtsi_pkg::REG_IN_DEPTH:   in_depth_q   <= cfg_data_i;
        dtsi_pkg::REG_IN_WIDTH:   in_width_q   <= cfg_data_i;
        dtsi_pkg::REG_IN_HEIGHT:  in_height_q  <= cfg_data_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Sizes are taken at DIM_BITS: zero-extend then keep the low DB bits.
  logic [DB+CW-1:0] od_x, ow_x, oh_x, id_x, iw_x, ih_x;
  assign od_x = {{DB{1'b0}}, out_depth_q};
  assign ow_x = {{DB{1'b0}}, out_width_q};
  assign oh_x = {{DB{1'b0}}, out_height_q};
  assign id_x = {{DB{1'b0}}, in_depth_q};
  assign iw_x = {{DB{1'b0}}, in_width_q};
  assign ih_x = {{DB{1'b0}}, in_height_q};

  logic [DB-1:0] od, ow, oh, id, iw, ih;
  logic [BW-1:0] bs;
  // a zero divisor behaves as one
  assign od = (od_x[DB-1:0] == '0) ? DB'(1) : od_x[DB-1:0];
  assign ow = (ow_x[DB-1:0] == '0) ? DB'(1) : ow_x[DB-1:0];
  assign oh = (oh_x[DB-1:0] == '0) ? DB'(1) : oh_x[DB-1:0];
  assign bs = (blk_edge_q == '0) ? BW'(1) : blk_edge_q;
  assign id = id_x[DB-1:0];
  assign iw = iw_x[DB-1:0];
  assign ih = ih_x[DB-1:0];

  // ---------------------------------------------------------------------------
  // Flow control: every stage moves together unless the output beat waits.
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv     = !valid_o || !stall_i;
  assign stall_o = !adv;

  // ---------------------------------------------------------------------------
  // Coordinate split: idx -> d, w, h, b, then h and w by block size
  // ---------------------------------------------------------------------------
  // div1: idx / od -> q, d
  logic          v1;
  logic [IB-1:0] q1, p1_idx;
  logic [DB-1:0] d1;
  dtsi_div #(.NW(IB), .DW(DB), .PW(IB)) u_div_d (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(valid_i), .dividend_i(out_index_i), .divisor_i(od), .payload_i(out_index_i),
    .valid_o(v1), .quot_o(q1), .rem_o(d1), .payload_o(p1_idx)
  );

  // div2: q / ow -> q2, w
  localparam int unsigned PW2 = IB + DB;
  logic           v2;
  logic [IB-1:0]  q2;
  logic [DB-1:0]  w2;
  logic [PW2-1:0] pl2;
  dtsi_div #(.NW(IB), .DW(DB), .PW(PW2)) u_div_w (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(v1), .dividend_i(q1), .divisor_i(ow), .payload_i({p1_idx, d1}),
    .valid_o(v2), .quot_o(q2), .rem_o(w2), .payload_o(pl2)
  );

  // div3: q2 / oh -> b, h
  localparam int unsigned PW3 = IB + 2*DB;
  logic           v3;
  logic [IB-1:0]  b3;
  logic [DB-1:0]  h3;
  logic [PW3-1:0] pl3;
  dtsi_div #(.NW(IB), .DW(DB), .PW(PW3)) u_div_h (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(v2), .dividend_i(q2), .divisor_i(oh), .payload_i({pl2, w2}),
    .valid_o(v3), .quot_o(b3), .rem_o(h3), .payload_o(pl3)
  );

  // pl3 = {idx, d, w}
  // div4: h / bs -> src_h, off_h; carry {idx, d, b, w}
  localparam int unsigned PW4 = 2*IB + 2*DB;
  logic           v4;
  logic [DB-1:0]  src_h4;
  logic [BW-1:0]  off_h4;
  logic [PW4-1:0] pl4;
  dtsi_div #(.NW(DB), .DW(BW), .PW(PW4)) u_div_bh (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(v3), .dividend_i(h3), .divisor_i(bs),
    .payload_i({pl3[PW3-1:DB], b3, pl3[DB-1:0]}),
    .valid_o(v4), .quot_o(src_h4), .rem_o(off_h4), .payload_o(pl4)
  );

  // div5: w / bs -> src_w, off_w; carry {idx, d, b, src_h, off_h}
  localparam int unsigned PW5 = 2*IB + 2*DB + BW;
  logic           v5;
  logic [DB-1:0]  src_w5;
  logic [BW-1:0]  off_w5;
  logic [PW5-1:0] pl5;
  dtsi_div #(.NW(DB), .DW(BW), .PW(PW5)) u_div_bw (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(v4), .dividend_i(pl4[DB-1:0]), .divisor_i(bs),
    .payload_i({pl4[PW4-1:DB], src_h4, off_h4}),
    .valid_o(v5), .quot_o(src_w5), .rem_o(off_w5), .payload_o(pl5)
  );

  // unpack pl5 = {idx, d, b, src_h, off_h}
  logic [IB-1:0] idx5, b5;
  logic [DB-1:0] d5, src_h5;
  logic [BW-1:0] off_h5;
  assign off_h5 = pl5[BW-1:0];
  assign src_h5 = pl5[BW +: DB];
  assign b5     = pl5[BW+DB +: IB];
  assign d5     = pl5[BW+DB+IB +: DB];
  assign idx5   = pl5[BW+2*DB+IB +: IB];

  // ---------------------------------------------------------------------------
  // Index assembly: up to two multiplies per stage, sums wrap at INDEX_BITS
  // ---------------------------------------------------------------------------
  // Stage A: ih*b, off_h*bs
  logic          va_q;
  logic [IB-1:0] a_idx_q, a_p1_q;
  logic [DB-1:0] a_d_q, a_srch_q, a_srcw_q;
  logic [BW-1:0] a_offw_q;
  logic [2*BW-1:0] a_o1_q;
  logic [DB+IB-1:0] mul_a;
  assign mul_a = ih * b5;

  // Stage B: iw*(src_h + p1), (o1 + off_w)*od
  logic          vb_q;
  logic [IB-1:0] b_idx_q, b_p2_q, b_sdp_q;
  logic [DB-1:0] b_d_q, b_srcw_q;
  logic [IB-1:0] pix1;
  logic [2*BW:0] offs;
  logic [DB+IB-1:0] mul_b;
  logic [2*BW+DB:0] mul_o;
  assign pix1  = IB'(a_srch_q) + a_p1_q;
  assign mul_b = iw * pix1;
  assign offs  = {1'b0, a_o1_q} + (2*BW+1)'(a_offw_q);
  assign mul_o = offs * od;

  // Stage C: id*(src_w + p2), d + sdp
  logic          vc_q;
  logic [IB-1:0] c_idx_q, c_p3_q, c_srcd_q;
  logic [IB-1:0] pix2;
  logic [DB+IB-1:0] mul_c;
  assign pix2  = IB'(b_srcw_q) + b_p2_q;
  assign mul_c = id * pix2;

  // Stage D: final sum into the output register
  logic          vd_q;
  logic [IB-1:0] d_idx_q, d_src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (adv) begin
      va_q <= v5;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_idx_q  <= idx5;
      a_p1_q   <= mul_a[IB-1:0];
      a_d_q    <= d5;
      a_srch_q <= src_h5;
      a_srcw_q <= src_w5;
      a_offw_q <= off_w5;
      a_o1_q   <= off_h5 * bs;

      b_idx_q  <= a_idx_q;
      b_p2_q   <= mul_b[IB-1:0];
      b_sdp_q  <= IB'(mul_o);
      b_d_q    <= a_d_q;
      b_srcw_q <= a_srcw_q;

      c_idx_q  <= b_idx_q;
      c_p3_q   <= mul_c[IB-1:0];
      c_srcd_q <= IB'(b_d_q) + b_sdp_q;

      d_idx_q  <= c_idx_q;
      d_src_q  <= c_srcd_q + c_p3_q;
    end
  end

  assign valid_o        = vd_q;
  assign dest_index_o   = d_idx_q;
  assign source_index_o = d_src_q;

endmodule
